FILE: hdl/sipc_pkg.sv
// Package for the steering IIR PWM controller: widths, fixed-point constants,
// payload structs and the control structs of the serial arithmetic units.
// No dependencies; every other file of the block imports it.
package sipc_pkg;

	// Field widths
	localparam int POS_W     = 16;
	localparam int ANG_W     = 16;
	localparam int DUTY_W    = 15;
	localparam int COEF_W    = 24;
	localparam int NUM_COEF  = 5;
	localparam int CFG_IDX_W = 3;

	// Serial multiply-accumulate unit (radix-4 Booth, one digit per cycle)
	localparam int MAC_W    = 52;
	localparam int MCAND_W  = 30;
	localparam int MPLIER_W = 24;
	localparam int DIG_N    = MPLIER_W / 2;

	// Error path and the serial divide by 34 (two quotient bits per cycle)
	localparam int ERR_W     = 30;
	localparam int DIV_STEPS = ERR_W / 2;
	localparam int REM_W     = 6;
	localparam int MEAS_W    = 29;
	localparam int UMAG_W    = 21;

	// Fixed-point constants
	localparam logic [MCAND_W-1:0] DEG_GAIN   = 30'd372340215;
	localparam logic [ERR_W-1:0]   DEG_OFFS   = 30'd133297812;
	localparam logic [ERR_W-1:0]   ROUND_DIV  = 30'd17;
	localparam logic [REM_W:0]     NORM_DIV   = 7'd34;
	localparam logic [MCAND_W-1:0] DUTY_SCALE = 30'd16499;
	localparam logic [DUTY_W-1:0]  DUTY_BASE  = 15'd500;
	localparam logic [MAC_W-1:0]   HALF_Q20   = 52'd524288;
	localparam logic [UMAG_W-1:0]  ONE_Q20    = 21'd1048576;
	localparam logic signed [ANG_W-1:0] ANGLE_LIMIT   = 16'sd8704;
	localparam logic signed [ANG_W-1:0] ANGLE_LIMIT_N = -16'sd8704;
	localparam logic [ERR_W-1:0] E_POS_MAX = 30'd8388607;
	localparam logic [ERR_W-1:0] E_NEG_MAX = 30'd8388608;
	localparam logic signed [COEF_W-1:0] E_MAX = 24'sh7FFFFF;
	localparam logic signed [COEF_W-1:0] E_MIN = -24'sh800000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_COEF_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_COEF_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_COEF_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COEF_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COEF_2 = 3'd4;

	typedef struct packed {
		logic [POS_W-1:0]        position_reading;
		logic signed [ANG_W-1:0] target_angle;
	} sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_forward;
		logic [DUTY_W-1:0] duty_reverse;
	} duty_t;

	typedef struct packed {
		logic step;
		logic load;
		logic clr;
	} mac_ctrl_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

FILE: hdl/steering_iir_pwm_controller.sv
// Steering controller top level: a sequencer around a serial Booth MAC and a divider.
// Depends on sipc_pkg, sipc_booth_mac and sipc_div34.
//
// Each accepted item (position reading, target angle) yields exactly one pair of
// H-bridge duty values. The block works on one item at a time: it accepts the item
// while idle, scales the reading into degrees, forms and rounds the error, divides
// it by 34, saturates the normalized error, forms the five filter products, rounds
// and clamps the output, scales it into a duty value, then loads the output register.
// The work is done by the shared radix-4 Booth multiplier, which retires two multiplier
// bits per cycle over seven products, and by the two-bit-per-cycle divider. The next
// item can be accepted while a finished result still waits in the output register.
// Coefficients are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, as the block itself does not enforce
// this. Indexes beyond the fifth are ignored.
module steering_iir_pwm_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  sipc_pkg::sample_t                    sample,
	output logic                                 duty_valid,
	input  logic                                 duty_ready,
	output sipc_pkg::duty_t                      duty,
	input  logic                                 cfg_we,
	input  logic [sipc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sipc_pkg::COEF_W-1:0]          cfg_data
);
	import sipc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MEAS  = 4'd1;
	localparam logic [3:0] S_ERR_A = 4'd2;
	localparam logic [3:0] S_ERR_B = 4'd3;
	localparam logic [3:0] S_ERR_C = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_E_SET = 4'd6;
	localparam logic [3:0] S_MAC   = 4'd7;
	localparam logic [3:0] S_RND_A = 4'd8;
	localparam logic [3:0] S_RND_B = 4'd9;
	localparam logic [3:0] S_DUTY  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	localparam logic [3:0] DIG_LAST = 4'(DIG_N - 1);
	localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);
	localparam logic [2:0] TAP_LAST = 3'(NUM_COEF - 1);

	// Sequencer state.
	logic [3:0] state_q;
	logic [3:0] dig_q;
	logic [2:0] tap_q;

	// Coefficients and filter history.
	logic signed [COEF_W-1:0] coef_q     [NUM_COEF];
	logic signed [COEF_W-1:0] err_hist_q [2];
	logic signed [COEF_W-1:0] out_hist_q [2];

	// Working registers of the current item.
	logic [POS_W-1:0]        reading_q;
	logic signed [ANG_W-1:0] tgt_q;
	logic [MEAS_W-1:0]       meas_q;
	logic [ERR_W-1:0]        err_q;
	logic signed [COEF_W-1:0] e_q;
	logic [MAC_W-1:0]        rnd_mag_q;
	logic                    rnd_neg_q;
	logic [UMAG_W-1:0]       umag_q;
	logic                    fwd_q;

	// Output register.
	logic  duty_valid_q;
	duty_t duty_q;

	// Combinational helpers.
	logic                     accept;
	logic signed [ANG_W-1:0]  tgt_clamped;
	mac_ctrl_t                mac_ctrl;
	logic signed [MCAND_W-1:0] mac_mcand;
	logic [MPLIER_W-1:0]      mac_mplier;
	logic signed [MAC_W-1:0]  mac_acc;
	logic signed [COEF_W-1:0] tap_data;
	div_ctrl_t                div_ctrl;
	logic [ERR_W-1:0]         dividend;
	logic [ERR_W-1:0]         quotient;
	logic [MEAS_W+16:0]       meas_sum;
	logic [31:0]              rnd_q20;
	logic [UMAG_W-1:0]        umag_next;
	logic signed [COEF_W-1:0] u_next;
	logic [DUTY_W-1:0]        duty_val;
	logic                     out_free;

	assign accept       = sample_valid && sample_ready;
	assign sample_ready = (state_q == S_IDLE);
	assign out_free     = !duty_valid_q || duty_ready;

	// The target is clamped to plus or minus 34 degrees as it is taken in.
	always_comb begin
		if (sample.target_angle > ANGLE_LIMIT) begin
			tgt_clamped = ANGLE_LIMIT;
		end else if (sample.target_angle < ANGLE_LIMIT_N) begin
			tgt_clamped = ANGLE_LIMIT_N;
		end else begin
			tgt_clamped = sample.target_angle;
		end
	end

	// Operand steering for the shared multiplier. The filter taps are taken in
	// order: current error, the two older errors, then the two older outputs, all
	// summed into one accumulator in Q.40.
	always_comb begin
		case (tap_q)
			3'd0:    tap_data = e_q;
			3'd1:    tap_data = err_hist_q[0];
			3'd2:    tap_data = err_hist_q[1];
			3'd3:    tap_data = out_hist_q[0];
			default: tap_data = out_hist_q[1];
		endcase

		mac_ctrl   = '0;
		mac_mcand  = DEG_GAIN;
		mac_mplier = MPLIER_W'(reading_q);
		case (state_q)
			S_MEAS: begin
				mac_ctrl.step = 1'b1;
			end
			S_MAC: begin
				mac_ctrl.step = 1'b1;
				mac_mcand     = MCAND_W'(tap_data);
				mac_mplier    = coef_q[tap_q];
			end
			S_DUTY: begin
				mac_ctrl.step = 1'b1;
				mac_mcand     = DUTY_SCALE;
				mac_mplier    = MPLIER_W'(umag_q);
			end
			default: begin
				mac_ctrl.step = 1'b0;
			end
		endcase
		mac_ctrl.load = mac_ctrl.step && (dig_q == '0);
		// The accumulator keeps running across the five filter taps.
		mac_ctrl.clr  = mac_ctrl.load && !((state_q == S_MAC) && (tap_q != '0));
	end

	sipc_booth_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.mcand  (mac_mcand),
		.mplier (mac_mplier),
		.acc    (mac_acc)
	);

	// Division by 34 rounds half away from zero: the magnitude plus 17 is divided
	// and the sign is put back afterwards.
	assign dividend      = err_q[ERR_W-1] ? (ROUND_DIV - err_q) : (err_q + ROUND_DIV);
	assign div_ctrl.load = (state_q == S_ERR_C);
	assign div_ctrl.step = (state_q == S_DIV);

	sipc_div34 u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (dividend),
		.quotient (quotient)
	);

	// Reading times gain in Q.36, rounded half up to Q.20 degrees.
	assign meas_sum = {1'b0, mac_acc[MEAS_W+15:0]} + (MEAS_W+17)'(32768);

	// Rounded output magnitude, clamped to one, and the signed output for the history.
	always_comb begin
		rnd_q20 = rnd_mag_q[MAC_W-1:20];
		if (rnd_q20 > 32'(ONE_Q20)) begin
			umag_next = ONE_Q20;
		end else begin
			umag_next = rnd_q20[UMAG_W-1:0];
		end
		if (rnd_neg_q) begin
			u_next = -COEF_W'(umag_next);
		end else begin
			u_next = COEF_W'(umag_next);
		end
	end

	// The duty base sits above the fraction bits, so it adds to the integer part.
	assign duty_val = mac_acc[DUTY_W+19:20] + DUTY_BASE;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dig_q   <= '0;
			tap_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					dig_q <= '0;
					tap_q <= '0;
					if (accept) begin
						state_q <= S_MEAS;
					end
				end
				S_MEAS: begin
					if (dig_q == DIG_LAST) begin
						dig_q   <= '0;
						state_q <= S_ERR_A;
					end else begin
						dig_q <= dig_q + 4'd1;
					end
				end
				S_ERR_A: state_q <= S_ERR_B;
				S_ERR_B: state_q <= S_ERR_C;
				S_ERR_C: state_q <= S_DIV;
				S_DIV: begin
					if (dig_q == DIV_LAST) begin
						dig_q   <= '0;
						state_q <= S_E_SET;
					end else begin
						dig_q <= dig_q + 4'd1;
					end
				end
				S_E_SET: state_q <= S_MAC;
				S_MAC: begin
					if (dig_q == DIG_LAST) begin
						dig_q <= '0;
						if (tap_q == TAP_LAST) begin
							tap_q   <= '0;
							state_q <= S_RND_A;
						end else begin
							tap_q <= tap_q + 3'd1;
						end
					end else begin
						dig_q <= dig_q + 4'd1;
					end
				end
				S_RND_A: state_q <= S_RND_B;
				S_RND_B: state_q <= S_DUTY;
				S_DUTY: begin
					if (dig_q == DIG_LAST) begin
						dig_q   <= '0;
						state_q <= S_FIN;
					end else begin
						dig_q <= dig_q + 4'd1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Coefficient registers; writes to indexes past the list fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ERR_COEF_0: coef_q[0] <= cfg_data;
				CFG_ERR_COEF_1: coef_q[1] <= cfg_data;
				CFG_ERR_COEF_2: coef_q[2] <= cfg_data;
				CFG_OUT_COEF_1: coef_q[3] <= cfg_data;
				CFG_OUT_COEF_2: coef_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter history is shifted once per item, when the new output is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_hist_q[0] <= '0;
			err_hist_q[1] <= '0;
			out_hist_q[0] <= '0;
			out_hist_q[1] <= '0;
		end else if (state_q == S_RND_B) begin
			err_hist_q[1] <= err_hist_q[0];
			err_hist_q[0] <= e_q;
			out_hist_q[1] <= out_hist_q[0];
			out_hist_q[0] <= u_next;
		end
	end

	// Datapath registers of the item in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			reading_q <= sample.position_reading;
			tgt_q     <= tgt_clamped;
		end
		if (state_q == S_ERR_A) begin
			meas_q <= meas_sum[MEAS_W+15:16];
		end
		if (state_q == S_ERR_B) begin
			// Target in Q.20 plus the offset, minus the scaled reading.
			err_q <= ERR_W'({{2{tgt_q[ANG_W-1]}}, tgt_q, 12'b0}) + DEG_OFFS
				- ERR_W'(meas_q);
		end
		if (state_q == S_E_SET) begin
			if (err_q[ERR_W-1]) begin
				e_q <= (quotient > E_NEG_MAX) ? E_MIN : -quotient[COEF_W-1:0];
			end else begin
				e_q <= (quotient > E_POS_MAX) ? E_MAX : quotient[COEF_W-1:0];
			end
		end
		if (state_q == S_RND_A) begin
			rnd_neg_q <= mac_acc[MAC_W-1];
			rnd_mag_q <= mac_acc[MAC_W-1] ? (HALF_Q20 - mac_acc) : (mac_acc + HALF_Q20);
		end
		if (state_q == S_RND_B) begin
			umag_q <= umag_next;
			// An output of exactly zero drives the reverse side.
			fwd_q  <= !rnd_neg_q && (umag_next != '0);
		end
	end

	// Output register: a result waits here while the next item is taken in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_valid_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			duty_valid_q <= 1'b1;
		end else if (duty_ready) begin
			duty_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			if (fwd_q) begin
				duty_q.duty_forward <= duty_val;
				duty_q.duty_reverse <= '0;
			end else begin
				duty_q.duty_forward <= '0;
				duty_q.duty_reverse <= duty_val;
			end
		end
	end

	assign duty_valid = duty_valid_q;
	assign duty       = duty_q;

	// Exactly one bridge side is driven, and its duty lies in the base-to-full range.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		duty_valid |-> ((duty.duty_forward == '0) != (duty.duty_reverse == '0))
			&& ((duty.duty_forward | duty.duty_reverse) >= DUTY_BASE)
			&& ((duty.duty_forward | duty.duty_reverse) <= 15'd16999))
		else $error("duty pair malformed");

	// The clamped output magnitude never exceeds one.
	a_umag_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUTY) |-> (umag_q <= ONE_Q20))
		else $error("output magnitude above one");

	// A finished item reaches the output register once the slot is free.
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_free) |=> (duty_valid && (state_q == S_IDLE)))
		else $error("result not loaded");

	// No new item is accepted while one is being worked on.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == S_MEAS) && !sample_ready))
		else $error("item accepted while busy");

endmodule

FILE: hdl/sipc_booth_mac.sv
// Radix-4 Booth multiply-accumulate unit that retires one multiplier digit per cycle.
// Depends on sipc_pkg for widths and the control struct.
module sipc_booth_mac (
	input  logic                                   clk,
	input  sipc_pkg::mac_ctrl_t                    ctrl,
	input  logic signed [sipc_pkg::MCAND_W-1:0]    mcand,
	input  logic [sipc_pkg::MPLIER_W-1:0]          mplier,
	output logic signed [sipc_pkg::MAC_W-1:0]      acc
);
	import sipc_pkg::*;

	logic signed [MAC_W-1:0]  mcand_q;
	logic signed [MPLIER_W:0] mplier_q;
	logic signed [MAC_W-1:0]  acc_q;
	logic signed [MAC_W-1:0]  cur_mcand;
	logic signed [MPLIER_W:0] cur_mplier;
	logic signed [MAC_W-1:0]  pp;

	// A load cycle takes the new operands straight in and also retires the first digit.
	always_comb begin
		if (ctrl.load) begin
			cur_mcand  = MAC_W'(mcand);
			cur_mplier = {mplier, 1'b0};
		end else begin
			cur_mcand  = mcand_q;
			cur_mplier = mplier_q;
		end
		case (cur_mplier[2:0])
			3'b001, 3'b010: pp = cur_mcand;
			3'b011:         pp = cur_mcand <<< 1;
			3'b100:         pp = -(cur_mcand <<< 1);
			3'b101, 3'b110: pp = -cur_mcand;
			default:        pp = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			acc_q    <= (ctrl.clr ? '0 : acc_q) + pp;
			mcand_q  <= cur_mcand <<< 2;
			mplier_q <= cur_mplier >>> 2;
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/sipc_div34.sv
// Restoring divider by the constant 34, two quotient bits per cycle.
// Depends on sipc_pkg for widths and the control struct.
module sipc_div34 (
	input  logic                          clk,
	input  sipc_pkg::div_ctrl_t           ctrl,
	input  logic [sipc_pkg::ERR_W-1:0]    dividend,
	output logic [sipc_pkg::ERR_W-1:0]    quotient
);
	import sipc_pkg::*;

	logic [ERR_W-1:0] shift_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W:0]   r1, r2, d1, d2;
	logic             ge1, ge2;

	always_comb begin
		r1  = {rem_q, shift_q[ERR_W-1]};
		ge1 = (r1 >= NORM_DIV);
		d1  = ge1 ? (r1 - NORM_DIV) : r1;
		r2  = {d1[REM_W-1:0], shift_q[ERR_W-2]};
		ge2 = (r2 >= NORM_DIV);
		d2  = ge2 ? (r2 - NORM_DIV) : r2;
	end

	// Quotient bits shift in at the bottom as dividend bits leave at the top.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (ctrl.step) begin
			shift_q <= {shift_q[ERR_W-3:0], ge1, ge2};
			rem_q   <= d2[REM_W-1:0];
		end
	end

	assign quotient = shift_q;

endmodule
